[hw/rtl/wall_transform_clip_project_top_defines.svh]
// assertion macros for the wall transform block
`ifndef WALL_TRANSFORM_CLIP_PROJECT_TOP_DEFINES_SVH
`define WALL_TRANSFORM_CLIP_PROJECT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define WTC_ASSERT_IMPL(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: lbl");
`define WTC_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("%m: lbl");
`else
`define WTC_ASSERT_IMPL(lbl, clk, rst, prop)
`define WTC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[hw/rtl/wtc_pkg.sv]
// shared types and constants for the wall transform block
`default_nettype none
package wtc_pkg;
   localparam logic [2:0] ST_VISIBLE  = 3'd0;
   localparam logic [2:0] ST_BEHIND   = 3'd1;
   localparam logic [2:0] ST_PARALLEL = 3'd2;
   localparam logic [2:0] ST_OFF_R    = 3'd3;
   localparam logic [2:0] ST_OFF_L    = 3'd4;
   localparam logic [2:0] ST_BACKFACE = 3'd5;

   localparam logic [1:0] KIND_SOLID = 2'd0;
   localparam logic [1:0] KIND_UPPER = 2'd1;
   localparam logic [1:0] KIND_LOWER = 2'd2;
   localparam logic [1:0] KIND_OPEN  = 2'd3;

   localparam logic [2:0] REG_EYE_X  = 3'd0;
   localparam logic [2:0] REG_EYE_Y  = 3'd1;
   localparam logic [2:0] REG_EYE_H  = 3'd2;
   localparam logic [2:0] REG_SIN    = 3'd3;
   localparam logic [2:0] REG_COS    = 3'd4;
   localparam logic [2:0] REG_HSCALE = 3'd5;
   localparam logic [2:0] REG_VSCALE = 3'd6;

   typedef struct packed {
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] second_x;
      logic signed [15:0] second_y;
      logic signed [15:0] ceiling_height;
      logic signed [15:0] floor_level;
      logic               has_back;
      logic signed [15:0] back_ceiling;
      logic signed [15:0] back_floor;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [1:0]         wall_kind;
      logic signed [15:0] left_column;
      logic signed [15:0] right_column;
      logic signed [31:0] left_ceiling_row;
      logic signed [31:0] left_floor_row;
      logic signed [31:0] right_ceiling_row;
      logic signed [31:0] right_floor_row;
      logic signed [31:0] left_back_ceiling_row;
      logic signed [31:0] left_back_floor_row;
      logic signed [31:0] right_back_ceiling_row;
      logic signed [31:0] right_back_floor_row;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] eye_x;
      logic signed [15:0] eye_y;
      logic signed [15:0] eye_height;
      logic signed [7:0]  view_sin;
      logic signed [7:0]  view_cos;
      logic [14:0]        horiz_fov_scale;
      logic [14:0]        vert_fov_scale;
   } cfg_type;

   // pipeline stall control type; the top level uses its own advance signal instead
   typedef struct packed {
      logic advance;
      logic flush;
   } pipe_ctl_type;
endpackage
`default_nettype wire

[hw/rtl/wtc_stream_if.sv]
// valid/ready stream interface carrying one payload
`default_nettype none
interface wtc_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/wall_transform_clip_project_top.sv]
// top level of the wall transform, near clip and projection pipeline
`default_nettype none
`include "wall_transform_clip_project_top_defines.svh"
// One wall per cycle enters the pipeline, so a transfer can be
// taken on every clock while the output is free. A result passes through
// the registers in order: 6 stages for translate, rotate, near plane tests
// and slope setup, the slope divider (input register plus 48 quotient
// stages), 2 stages for the clip move, the divider bank for the column and
// row scales, and 3 stages for columns, culling, rows and the output
// register. Latency does not depend on SCREEN_WIDTH. The whole pipeline
// stalls as one when the output register is full and not taken; a stall
// loses and repeats nothing. Write configuration only while the
// pipeline is empty.
module wall_transform_clip_project_top #(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 224,
   parameter int FRAC_BITS     = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   wtc_stream_if.sink       req,
   wtc_stream_if.source     rsp,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   localparam int MIN_Z   = (2 << FRAC_BITS) / 10;
   localparam int PAR_DZ  = (1 << FRAC_BITS) / 10;
   localparam longint ROW_C = (longint'(SCREEN_HEIGHT) << (2 * FRAC_BITS)) / 2;
   localparam int COL_C   = SCREEN_WIDTH / 2;
   localparam int DW      = 48;   // numerator width of divides
   localparam int N1      = 6;    // stages before slope divide
   localparam int L1      = DW + 1;
   localparam int N2      = 2;    // clip move stages
   localparam int L2      = DW + 1;
   localparam int N3      = 2;    // column and row stages before the output register
   localparam int DEPTH   = N1 + L1 + N2 + L2 + N3;

   wtc_pkg::cfg_type cfg_ff;

   // ---------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eye_x           <= '0;
         cfg_ff.eye_y           <= '0;
         cfg_ff.eye_height      <= '0;
         cfg_ff.view_sin        <= '0;
         cfg_ff.view_cos        <= 8'sd64;
         cfg_ff.horiz_fov_scale <= 15'd256;
         cfg_ff.vert_fov_scale  <= 15'd224;
      end else if (csr_write) begin
         unique case (csr_index)
            wtc_pkg::REG_EYE_X:  cfg_ff.eye_x           <= csr_data;
            wtc_pkg::REG_EYE_Y:  cfg_ff.eye_y           <= csr_data;
            wtc_pkg::REG_EYE_H:  cfg_ff.eye_height      <= csr_data;
            wtc_pkg::REG_SIN:    cfg_ff.view_sin        <= csr_data[7:0];
            wtc_pkg::REG_COS:    cfg_ff.view_cos        <= csr_data[7:0];
            wtc_pkg::REG_HSCALE: cfg_ff.horiz_fov_scale <= csr_data[14:0];
            wtc_pkg::REG_VSCALE: cfg_ff.vert_fov_scale  <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // ---------------- global stall: whole pipe moves when output can take
   logic              out_v_ff;
   logic              advance;
   logic [DEPTH-1:0]  v_ff;
   assign advance   = !out_v_ff || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= {v_ff[DEPTH-2:0], req.valid};
   end

   // ---------------- per item context carried alongside the math
   typedef struct packed {
      logic signed [15:0] yc;
      logic signed [15:0] yf;
      logic signed [15:0] nyc;
      logic signed [15:0] nyf;
      logic [1:0]         kind;
   } ctx_type;

   // stage A: translate
   logic signed [15:0] a_tx1_ff, a_ty1_ff, a_tx2_ff, a_ty2_ff;
   ctx_type            a_ctx_ff;
   ctx_type            a_ctx_in;
   always_comb begin
      a_ctx_in.yc  = req.data.ceiling_height - cfg_ff.eye_height;
      a_ctx_in.yf  = req.data.floor_level - cfg_ff.eye_height;
      a_ctx_in.nyc = req.data.back_ceiling - cfg_ff.eye_height;
      a_ctx_in.nyf = req.data.back_floor - cfg_ff.eye_height;
      if (!req.data.has_back) a_ctx_in.kind = wtc_pkg::KIND_SOLID;
      else if (req.data.back_ceiling < req.data.floor_level)
         a_ctx_in.kind = wtc_pkg::KIND_UPPER;
      else if (req.data.back_floor > req.data.ceiling_height)
         a_ctx_in.kind = wtc_pkg::KIND_LOWER;
      else a_ctx_in.kind = wtc_pkg::KIND_OPEN;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         a_tx1_ff <= req.data.first_x - cfg_ff.eye_x;
         a_ty1_ff <= req.data.first_y - cfg_ff.eye_y;
         a_tx2_ff <= req.data.second_x - cfg_ff.eye_x;
         a_ty2_ff <= req.data.second_y - cfg_ff.eye_y;
         a_ctx_ff <= a_ctx_in;
      end
   end

   // stage B: products with sin and cos, shifted and wrapped
   logic signed [15:0] b_p_ff [8];
   ctx_type            b_ctx_ff;
   logic signed [23:0] b_prod_in [8];
   always_comb begin
      b_prod_in[0] = a_tx1_ff * cfg_ff.view_sin;
      b_prod_in[1] = a_ty1_ff * cfg_ff.view_cos;
      b_prod_in[2] = a_tx1_ff * cfg_ff.view_cos;
      b_prod_in[3] = a_ty1_ff * cfg_ff.view_sin;
      b_prod_in[4] = a_tx2_ff * cfg_ff.view_sin;
      b_prod_in[5] = a_ty2_ff * cfg_ff.view_cos;
      b_prod_in[6] = a_tx2_ff * cfg_ff.view_cos;
      b_prod_in[7] = a_ty2_ff * cfg_ff.view_sin;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 8; k++) b_p_ff[k] <= 16'(b_prod_in[k] >>> FRAC_BITS);
         b_ctx_ff <= a_ctx_ff;
      end
   end

   // stage C: rotated coordinates
   logic signed [15:0] c_rx1_ff, c_rz1_ff, c_rx2_ff, c_rz2_ff;
   ctx_type            c_ctx_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         c_rx1_ff <= b_p_ff[0] - b_p_ff[1];
         c_rz1_ff <= b_p_ff[2] + b_p_ff[3];
         c_rx2_ff <= b_p_ff[4] - b_p_ff[5];
         c_rz2_ff <= b_p_ff[6] + b_p_ff[7];
         c_ctx_ff <= b_ctx_ff;
      end
   end

   // stage D: near plane classification, edge deltas
   typedef struct packed {
      logic signed [15:0] rx1;
      logic signed [15:0] rz1;
      logic signed [15:0] rx2;
      logic signed [15:0] rz2;
      logic               lc;
      logic               rc;
      logic [2:0]         status;
      ctx_type            ctx;
   } geo_type;

   geo_type            d_ff, d_in;
   logic signed [15:0] d_dx_ff, d_dz_ff, dz_in;
   always_comb begin
      d_in.rx1 = c_rx1_ff;
      d_in.rz1 = c_rz1_ff;
      d_in.rx2 = c_rx2_ff;
      d_in.rz2 = c_rz2_ff;
      d_in.lc  = c_rz1_ff <= 16'(MIN_Z);
      d_in.rc  = c_rz2_ff <= 16'(MIN_Z);
      d_in.ctx = c_ctx_ff;
      dz_in    = c_rz2_ff - c_rz1_ff;
      if (d_in.lc && d_in.rc) d_in.status = wtc_pkg::ST_BEHIND;
      else if ((d_in.lc || d_in.rc) && (dz_in < 16'(PAR_DZ)) && (dz_in > -16'(PAR_DZ)))
         d_in.status = wtc_pkg::ST_PARALLEL;
      else d_in.status = wtc_pkg::ST_VISIBLE;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff    <= d_in;
         d_dx_ff <= c_rx2_ff - c_rx1_ff;
         d_dz_ff <= dz_in;
      end
   end

   // stage E: set up slope divide operands
   logic [DW-1:0]      e_num_ff;
   logic [15:0]        e_den_ff;
   logic               e_neg_ff;
   geo_type            e_ff;
   logic signed [DW-1:0] e_numv_in;
   always_comb e_numv_in = DW'(d_dx_ff) <<< FRAC_BITS;
   always_ff @(posedge clock) begin
      if (advance) begin
         e_num_ff <= e_numv_in[DW-1] ? DW'(-e_numv_in) : DW'(e_numv_in);
         // zero divisor only when no clip is needed; result unused then
         e_den_ff <= (d_dz_ff == 16'sd0) ? 16'd1 :
                     (d_dz_ff[15] ? 16'(-d_dz_ff) : 16'(d_dz_ff));
         e_neg_ff <= e_numv_in[DW-1] ^ d_dz_ff[15];
         e_ff     <= d_ff;
      end
   end

   // stage F: extra balance register before divider
   logic [DW-1:0] f_num_ff;
   logic [15:0]   f_den_ff;
   logic          f_neg_ff;
   geo_type       f_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         f_num_ff <= e_num_ff;
         f_den_ff <= e_den_ff;
         f_neg_ff <= e_neg_ff;
         f_ff     <= e_ff;
      end
   end

   logic [DW-1:0]           slope_q;
   logic [$bits(geo_type)-1:0] g_tag;
   geo_type                 g_geo;
   wtc_divider #(.NUM_W(DW), .DEN_W(16), .TAG_W($bits(geo_type))) u_slope_div (
      .clock(clock), .advance(advance), .num_mag(f_num_ff), .den_mag(f_den_ff),
      .neg(f_neg_ff), .tag(f_ff), .quot(slope_q), .tag_out(g_tag)
   );
   assign g_geo = geo_type'(g_tag);

   // stage H: multiply for clip move
   logic signed [15:0] h_slope;
   logic signed [15:0] h_dzc_in;
   logic signed [31:0] h_prod_ff;
   geo_type            h_ff;
   always_comb begin
      h_slope  = slope_q[15:0];
      h_dzc_in = 16'(MIN_Z) - (g_geo.lc ? g_geo.rz1 : g_geo.rz2);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         h_prod_ff <= h_dzc_in * h_slope;
         h_ff      <= g_geo;
      end
   end

   // stage I: clipped endpoint
   geo_type i_ff, i_in;
   logic signed [15:0] i_mv;
   always_comb begin
      i_in = h_ff;
      i_mv = 16'(h_prod_ff >>> FRAC_BITS);
      if (h_ff.lc && !h_ff.rc) begin
         i_in.rx1 = h_ff.rx1 + i_mv;
         i_in.rz1 = 16'(MIN_Z);
      end else if (h_ff.rc && !h_ff.lc) begin
         i_in.rx2 = h_ff.rx2 + i_mv;
         i_in.rz2 = 16'(MIN_Z);
      end
   end
   always_ff @(posedge clock) if (advance) i_ff <= i_in;

   // stage J: four divides by the positive z of each endpoint
   logic [DW-1:0] j_num_in [4];
   logic [15:0]   j_den_in [4];
   logic [DW-1:0] j_q [4];
   logic [$bits(geo_type)-1:0] j_tag [4];
   always_comb begin
      j_num_in[0] = DW'(cfg_ff.horiz_fov_scale) << FRAC_BITS;
      j_num_in[1] = DW'(cfg_ff.horiz_fov_scale) << FRAC_BITS;
      j_num_in[2] = DW'(cfg_ff.vert_fov_scale) << (2 * FRAC_BITS);
      j_num_in[3] = DW'(cfg_ff.vert_fov_scale) << (2 * FRAC_BITS);
      // z is positive whenever the result matters
      j_den_in[0] = i_ff.rz1[15] || i_ff.rz1 == 16'sd0 ? 16'd1 : i_ff.rz1;
      j_den_in[1] = i_ff.rz2[15] || i_ff.rz2 == 16'sd0 ? 16'd1 : i_ff.rz2;
      j_den_in[2] = j_den_in[0];
      j_den_in[3] = j_den_in[1];
   end
   for (genvar u = 0; u < 4; u++) begin : g_proj_div
      wtc_divider #(.NUM_W(DW), .DEN_W(16), .TAG_W($bits(geo_type))) u_div (
         .clock(clock), .advance(advance), .num_mag(j_num_in[u]),
         .den_mag(j_den_in[u]), .neg(1'b0), .tag(i_ff), .quot(j_q[u]),
         .tag_out(j_tag[u])
      );
   end
   geo_type k_geo;
   assign k_geo = geo_type'(j_tag[0]);

   // stage K: column products and row scales
   logic signed [31:0] k_cx1_ff, k_cx2_ff;
   logic signed [31:0] k_ys1_ff, k_ys2_ff;
   geo_type            k_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         k_cx1_ff <= k_geo.rx1 * $signed(j_q[0][15:0]);
         k_cx2_ff <= k_geo.rx2 * $signed(j_q[1][15:0]);
         k_ys1_ff <= j_q[2][31:0];
         k_ys2_ff <= j_q[3][31:0];
         k_ff     <= k_geo;
      end
   end

   // stage L: columns, culling, row products
   logic signed [15:0] l_x1_in, l_x2_in, l_x1_ff, l_x2_ff;
   logic [2:0]         l_st_in, l_st_ff;
   logic signed [47:0] l_m_ff [8];
   logic [1:0]         l_kind_ff;
   always_comb begin
      l_x1_in = 16'(COL_C) - 16'(k_cx1_ff >>> (2 * FRAC_BITS));
      l_x2_in = 16'(COL_C) - 16'(k_cx2_ff >>> (2 * FRAC_BITS));
      if (k_ff.status != wtc_pkg::ST_VISIBLE) l_st_in = k_ff.status;
      else if (l_x1_in > 16'(SCREEN_WIDTH - 1)) l_st_in = wtc_pkg::ST_OFF_R;
      else if (l_x2_in < 16'sd0) l_st_in = wtc_pkg::ST_OFF_L;
      else if (l_x1_in >= l_x2_in) l_st_in = wtc_pkg::ST_BACKFACE;
      else l_st_in = wtc_pkg::ST_VISIBLE;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         l_x1_ff   <= l_x1_in;
         l_x2_ff   <= l_x2_in;
         l_st_ff   <= l_st_in;
         l_kind_ff <= k_ff.ctx.kind;
         l_m_ff[0] <= k_ff.ctx.yc  * k_ys1_ff;
         l_m_ff[1] <= k_ff.ctx.yf  * k_ys1_ff;
         l_m_ff[2] <= k_ff.ctx.yc  * k_ys2_ff;
         l_m_ff[3] <= k_ff.ctx.yf  * k_ys2_ff;
         l_m_ff[4] <= k_ff.ctx.nyc * k_ys1_ff;
         l_m_ff[5] <= k_ff.ctx.nyf * k_ys1_ff;
         l_m_ff[6] <= k_ff.ctx.nyc * k_ys2_ff;
         l_m_ff[7] <= k_ff.ctx.nyf * k_ys2_ff;
      end
   end

   // stage M: rows and output register
   wtc_pkg::rsp_type out_ff, out_in;
   logic signed [31:0] m_row [8];
   logic               m_vis, m_open;
   always_comb begin
      for (int k = 0; k < 8; k++)
         m_row[k] = 32'(ROW_C) - 32'(l_m_ff[k] >>> FRAC_BITS);
      m_vis  = (l_st_ff == wtc_pkg::ST_VISIBLE);
      m_open = m_vis && (l_kind_ff == wtc_pkg::KIND_OPEN);
      out_in.status                 = l_st_ff;
      out_in.wall_kind              = m_vis ? l_kind_ff : wtc_pkg::KIND_SOLID;
      out_in.left_column            = m_vis ? l_x1_ff : '0;
      out_in.right_column           = m_vis ? l_x2_ff : '0;
      out_in.left_ceiling_row       = m_vis ? m_row[0] : '0;
      out_in.left_floor_row         = m_vis ? m_row[1] : '0;
      out_in.right_ceiling_row      = m_vis ? m_row[2] : '0;
      out_in.right_floor_row        = m_vis ? m_row[3] : '0;
      out_in.left_back_ceiling_row  = m_open ? m_row[4] : '0;
      out_in.left_back_floor_row    = m_open ? m_row[5] : '0;
      out_in.right_back_ceiling_row = m_open ? m_row[6] : '0;
      out_in.right_back_floor_row   = m_open ? m_row[7] : '0;
   end
   always_ff @(posedge clock) if (advance) out_ff <= out_in;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (advance) out_v_ff <= v_ff[DEPTH-1];
   end
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

   // culled results carry zero payload; held result stays put on stall
   `WTC_ASSERT_IMPL(a_cull_zero, clock, reset,
      rsp.valid && rsp.data.status != wtc_pkg::ST_VISIBLE |-> rsp.data.left_column == 16'sd0)
   `WTC_ASSERT_IMPL(a_stall_hold, clock, reset,
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
   `WTC_ASSERT_IMPL(a_ready_stall, clock, reset, !req.ready |-> out_v_ff && !rsp.ready)
   `WTC_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp.valid)
endmodule
`default_nettype wire

[hw/rtl/wtc_divider.sv]
// pipelined restoring divider, one quotient bit per stage, truncates toward zero
`default_nettype none
module wtc_divider #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16,
   parameter int TAG_W = 8
) (
   input  wire logic             clock,
   input  wire logic             advance,
   input  wire logic [NUM_W-1:0] num_mag,
   input  wire logic [DEN_W-1:0] den_mag,
   input  wire logic             neg,
   input  wire logic [TAG_W-1:0] tag,
   output logic      [NUM_W-1:0] quot,
   output logic      [TAG_W-1:0] tag_out
);
   logic [NUM_W-1:0] q_ff   [NUM_W+1];
   logic [NUM_W:0]   r_ff   [NUM_W+1];
   logic [DEN_W-1:0] d_ff   [NUM_W+1];
   logic             n_ff   [NUM_W+1];
   logic [TAG_W-1:0] t_ff   [NUM_W+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff[0] <= num_mag;
         r_ff[0] <= '0;
         d_ff[0] <= den_mag;
         n_ff[0] <= neg;
         t_ff[0] <= tag;
      end
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_step
      logic [NUM_W:0]   sh_in;
      logic [NUM_W:0]   diff_in;
      logic             ok_in;
      always_comb begin
         sh_in   = {r_ff[s][NUM_W-1:0], q_ff[s][NUM_W-1]};
         diff_in = sh_in - {{(NUM_W+1-DEN_W){1'b0}}, d_ff[s]};
         ok_in   = (sh_in >= {{(NUM_W+1-DEN_W){1'b0}}, d_ff[s]});
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            r_ff[s+1] <= ok_in ? diff_in : sh_in;
            q_ff[s+1] <= {q_ff[s][NUM_W-2:0], ok_in};
            d_ff[s+1] <= d_ff[s];
            n_ff[s+1] <= n_ff[s];
            t_ff[s+1] <= t_ff[s];
         end
      end
   end

   assign quot    = n_ff[NUM_W] ? (~q_ff[NUM_W] + 1'b1) : q_ff[NUM_W];
   assign tag_out = t_ff[NUM_W];
endmodule
`default_nettype wire
